[hw/rtl/lstc_pkg.sv]
// Shared types and constants of the line sensor threshold calibrator.
// Frame header codes, request mode codes, field widths and the default
// threshold table. No dependencies.
`timescale 1ns / 1ps

package lstc_pkg;

  localparam int MODE_W   = 2;
  localparam int CH_W     = 4;
  localparam int SMP_IN_W = 10;
  localparam int CFG_W    = 8;
  localparam int BYTE_W   = 8;
  localparam int TABLE_N  = 24;

  localparam logic [MODE_W-1:0] MODE_CAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DET = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIN = 2'd2;

  localparam logic [BYTE_W-1:0] HDR_ADJ_START = 8'h66;
  localparam logic [BYTE_W-1:0] HDR_ADJ_END   = 8'hBB;
  localparam logic [BYTE_W-1:0] HDR_DET_START = 8'h55;
  localparam logic [BYTE_W-1:0] HDR_DET_END   = 8'hAA;

  localparam logic [CFG_W-1:0] COUNT_RESET = 8'd60;

  typedef logic [7:0] thr_dflt_t [TABLE_N];

  localparam thr_dflt_t THR_DEFAULT = '{
    8'd141, 8'd155, 8'd155, 8'd138, 8'd174, 8'd160, 8'd138, 8'd136,
    8'd156, 8'd137, 8'd160, 8'd163, 8'd151, 8'd150, 8'd136, 8'd108,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
  };

endpackage

[hw/rtl/lstc_div.sv]
// Restoring divider, one quotient bit per cycle: NW-bit numerator by an
// CFG_W-bit nonzero divisor. Depends on lstc_pkg.
`timescale 1ns / 1ps

module lstc_div #(
  parameter int NW = 18
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [NW-1:0]            num,
  input  logic [lstc_pkg::CFG_W-1:0] den,
  output logic                     done,
  output logic [NW-1:0]            quo
);
  import lstc_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0]    cnt_r;
  logic             done_r;
  logic [NW-1:0]    num_r;
  logic [CFG_W-1:0] rem_r;
  logic [CFG_W-1:0] den_r;
  logic [CFG_W:0]   trial;
  logic             ge;
  logic [CFG_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, num_r[NW-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? CFG_W'(trial - {1'b0, den_r}) : CFG_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && (cnt_r == CW'(1));
      if (start) begin
        cnt_r <= CW'(NW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // Numerator shifts out at the top while quotient bits fill in at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      num_r <= {num_r[NW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

[hw/rtl/line_sensor_threshold_calibrator_core.sv]
// Top level of the line sensor threshold calibrator: per-channel sum, max and
// threshold storage, request sequencer and frame output.
// Depends on lstc_pkg and lstc_div.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready   | in_tdata: mode, channel, sample
//  out_    | out | out_tvalid/out_tready | out_tdata: out_byte; out_tlast: last
//  cfg_    | in  | cfg_we               | cfg_wdata: sample_count
//
// Calibrate and detect requests pass through S_CAL or S_DET back to idle;
// a detect on the last channel then holds for its 5-byte mask frame. Finish
// walks every channel through the shared serial divider, then sends the
// 2*CHANNELS+2 byte adjust frame.
// in_tready is high only while idle; output stalls hold the sequencer.
// Reset (rst_n low, synchronous) clears sums, maxima and mask, loads the
// default thresholds and sets sample_count to 60.
`timescale 1ns / 1ps

module line_sensor_threshold_calibrator_core #(
  parameter int CHANNELS    = 16,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [15:0]                in_tdata,   // [1:0] mode, [5:2] channel, [15:6] sample
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,  // [7:0] out_byte
  output logic                       out_tlast,
  input  logic                       cfg_we,
  input  logic [lstc_pkg::CFG_W-1:0] cfg_wdata   // [7:0] sample_count
);
  import lstc_pkg::*;

  localparam int IW       = $clog2(CHANNELS);
  localparam int SUM_BITS = SAMPLE_BITS + 8;
  localparam int THR_BITS = SAMPLE_BITS + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CAL   = 3'd1;
  localparam logic [2:0] S_DET   = 3'd2;
  localparam logic [2:0] S_FLOAD = 3'd3;
  localparam logic [2:0] S_FDIV  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  localparam logic [1:0] PH_HEAD = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_TAIL = 2'd2;

  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [SAMPLE_BITS-1:0] smp_t;
  typedef logic [THR_BITS-1:0]    thr_t;

  // input fields
  logic [MODE_W-1:0]   in_mode;
  logic [CH_W-1:0]     in_ch;
  logic [SMP_IN_W-1:0] in_smp;
  logic                in_ok;

  assign in_mode = in_tdata[1:0];
  assign in_ch   = in_tdata[5:2];
  assign in_smp  = in_tdata[15:6];
  assign in_ok   = int'(in_ch) < CHANNELS;

  // control state
  logic [2:0]       state_r, state_nxt;
  logic [1:0]       ph_r, ph_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic             hi_r, hi_nxt;
  logic [1:0]       mb_r, mb_nxt;
  logic             adj_r, adj_nxt;
  logic [CFG_W-1:0] cnt_r;
  logic [CHANNELS-1:0] mask_r, mask_nxt;

  // request payload
  logic [IW-1:0] ch_r;
  smp_t          smp_r;

  // storage
  sum_t sum_r [CHANNELS];
  smp_t max_r [CHANNELS];
  thr_t thr_r [CHANNELS];

  logic [IW-1:0] rd_ix;
  sum_t          sum_rd;
  smp_t          max_rd;
  thr_t          thr_rd;

  logic          cal_we;
  logic          fin_we;
  sum_t          sum_upd;
  logic [SUM_BITS:0] sum_wide;
  thr_t          thr_new;
  thr_t          two_max;
  sum_t          two_max_ext;

  logic             div_start;
  logic             div_done;
  sum_t             div_quo;
  logic [CFG_W-1:0] div_den;

  logic [15:0] thr16;
  logic [23:0] mask24;
  logic        last_ch;

  assign rd_ix  = (state_r == S_CAL || state_r == S_DET) ? ch_r : idx_r;
  assign sum_rd = sum_r[rd_ix];
  assign max_rd = max_r[rd_ix];
  assign thr_rd = thr_r[rd_ix];

  assign sum_wide = {1'b0, sum_rd} + (SUM_BITS+1)'(smp_r);
  assign sum_upd  = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];

  assign two_max     = {max_rd, 1'b0};
  assign two_max_ext = SUM_BITS'(two_max);
  // 2*max always fits the threshold width, so only the low clamp matters
  assign thr_new = (div_quo > two_max_ext) ? '0 : THR_BITS'(two_max_ext - div_quo);

  assign div_den = (cnt_r == '0) ? CFG_W'(1) : cnt_r;
  assign last_ch = (state_r == S_DET) ? (ch_r == IW'(CHANNELS - 1))
                                      : (idx_r == IW'(CHANNELS - 1));

  lstc_div #(
    .NW (SUM_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_rd),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    idx_nxt   = idx_r;
    hi_nxt    = hi_r;
    mb_nxt    = mb_r;
    adj_nxt   = adj_r;
    mask_nxt  = mask_r;
    cal_we    = 1'b0;
    fin_we    = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          priority if (in_mode == MODE_CAL && in_ok) begin
            state_nxt = S_CAL;
          end else if (in_mode == MODE_DET && in_ok) begin
            state_nxt = S_DET;
          end else if (in_mode == MODE_FIN) begin
            idx_nxt   = '0;
            state_nxt = S_FLOAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CAL: begin
        cal_we    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DET: begin
        if (SAMPLE_BITS'(smp_r) > thr_rd[SAMPLE_BITS-1:0] && !thr_rd[THR_BITS-1]) begin
          mask_nxt = mask_r | (CHANNELS'(1) << ch_r);
        end
        if (last_ch) begin
          adj_nxt   = 1'b0;
          ph_nxt    = PH_HEAD;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FLOAD: begin
        div_start = 1'b1;
        state_nxt = S_FDIV;
      end
      S_FDIV: begin
        if (div_done) begin
          fin_we = 1'b1;
          if (last_ch) begin
            adj_nxt   = 1'b1;
            ph_nxt    = PH_HEAD;
            state_nxt = S_EMIT;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_FLOAD;
          end
        end
      end
      S_EMIT: begin
        if (out_tready) begin
          unique case (ph_r)
            PH_HEAD: begin
              idx_nxt = '0;
              hi_nxt  = 1'b0;
              mb_nxt  = '0;
              ph_nxt  = PH_BODY;
            end
            PH_BODY: begin
              if (adj_r) begin
                hi_nxt = ~hi_r;
                if (hi_r) begin
                  if (last_ch) begin
                    ph_nxt = PH_TAIL;
                  end else begin
                    idx_nxt = idx_r + IW'(1);
                  end
                end
              end else begin
                mb_nxt = mb_r + 2'd1;
                if (mb_r == 2'd2) begin
                  ph_nxt = PH_TAIL;
                end
              end
            end
            default: begin
              // closing byte taken: drop the mask after its frame
              if (!adj_r) begin
                mask_nxt = '0;
              end
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output byte select
  assign thr16  = 16'(thr_rd);
  assign mask24 = 24'(mask_r);

  always_comb begin
    out_tvalid = (state_r == S_EMIT);
    out_tlast  = 1'b0;
    out_tdata  = '0;
    unique case (ph_r)
      PH_HEAD: out_tdata = adj_r ? HDR_ADJ_START : HDR_DET_START;
      PH_BODY: begin
        if (adj_r) begin
          out_tdata = hi_r ? thr16[15:8] : thr16[7:0];
        end else begin
          unique case (mb_r)
            2'd0:    out_tdata = mask24[7:0];
            2'd1:    out_tdata = mask24[15:8];
            default: out_tdata = mask24[23:16];
          endcase
        end
      end
      default: begin
        out_tdata = adj_r ? HDR_ADJ_END : HDR_DET_END;
        out_tlast = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= PH_HEAD;
      idx_r   <= '0;
      hi_r    <= 1'b0;
      mb_r    <= '0;
      adj_r   <= 1'b0;
      mask_r  <= '0;
      cnt_r   <= COUNT_RESET;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      idx_r   <= idx_nxt;
      hi_r    <= hi_nxt;
      mb_r    <= mb_nxt;
      adj_r   <= adj_nxt;
      mask_r  <= mask_nxt;
      if (cfg_we) begin
        cnt_r <= cfg_wdata;
      end
    end
  end

  // latch the request
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ch_r  <= IW'(in_ch);
      smp_r <= SAMPLE_BITS'(in_smp);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i] <= '0;
        max_r[i] <= '0;
        thr_r[i] <= (i < TABLE_N) ? THR_BITS'(THR_DEFAULT[i]) : '0;
      end
    end else if (cal_we) begin
      sum_r[rd_ix] <= sum_upd;
      if (smp_r > max_rd) begin
        max_r[rd_ix] <= smp_r;
      end
    end else if (fin_we) begin
      thr_r[rd_ix] <= thr_new;
      sum_r[rd_ix] <= '0;
      max_r[rd_ix] <= '0;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input ready while a frame is pending");

  a_frame_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("sequencer did not return to idle after a frame");

  a_div_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_FDIV))
    else $error("divider finished outside the finish walk");

  a_mask_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast && !adj_r) |=> (mask_r == '0))
    else $error("mask not cleared after its frame");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> !div_done)
    else $error("divider done right after start");

endmodule
